### design/bsm_pkg.sv
`default_nettype none

package bsm_pkg;

    // Field widths of the operand and result channels
    localparam int FIELD_W   = 16;
    localparam int PRODUCT_W = 32;

    // Booth operand width (2 to 32)
    localparam int WIDTH = 16;

    // Booth steps done in each pipeline stage
    localparam int STEPS_PER_STAGE = 2;
    localparam int NUM_STAGES      = (WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Step counter must hold WIDTH itself
    localparam int CNT_W = $clog2(WIDTH + 1);

    // Bit pair {Q0, Q-1} codes
    localparam logic [1:0] PAIR_ADD = 2'b01;
    localparam logic [1:0] PAIR_SUB = 2'b10;

    typedef struct packed {
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] q;
        logic             qm1;
        logic [WIDTH-1:0] m;
        logic [CNT_W-1:0] cnt;
    } bsm_work_t;

    // Sign-extend a field, then keep its low WIDTH bits
    function automatic logic [WIDTH-1:0] ext_operand(logic signed [FIELD_W-1:0] v);
        logic signed [63:0] x;
        x = 64'(v);
        return x[WIDTH-1:0];
    endfunction

    // Sign-extend or cut the 2*WIDTH-bit A,Q to the product field
    function automatic logic signed [PRODUCT_W-1:0] fit_product(bsm_work_t w);
        logic signed [2*WIDTH-1:0] aq;
        logic signed [127:0]       x;
        aq = {w.a, w.q};
        x  = 128'(aq);
        return x[PRODUCT_W-1:0];
    endfunction

    // One Booth step while steps remain: add/subtract M by the bit pair, then shift A,Q,Q-1 right
    function automatic bsm_work_t booth_step(bsm_work_t w);
        bsm_work_t        r;
        logic [WIDTH-1:0] a_sum;
        r     = w;
        a_sum = w.a;
        if (w.cnt < CNT_W'(WIDTH))
        begin
            unique case ({w.q[0], w.qm1})
                PAIR_ADD: a_sum = w.a + w.m;
                PAIR_SUB: a_sum = w.a - w.m;
                default:  a_sum = w.a;
            endcase
            r.qm1 = w.q[0];
            if (WIDTH > 1)
            begin
                r.q = {a_sum[0], w.q[WIDTH-1:1]};
                r.a = {a_sum[WIDTH-1], a_sum[WIDTH-1:1]};
            end
            r.cnt = w.cnt + CNT_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/bsm_in_if.sv
`default_nettype none

interface bsm_in_if
    import bsm_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] multiplicand;
    logic signed [FIELD_W-1:0] multiplier;

    modport source (output valid, output multiplicand, output multiplier, input ready);
    modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

`default_nettype wire

### design/bsm_out_if.sv
`default_nettype none

interface bsm_out_if
    import bsm_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [PRODUCT_W-1:0] product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

`default_nettype wire

### design/bsm_stage.sv
`default_nettype none

module bsm_stage
    import bsm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire bsm_work_t up_work,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output bsm_work_t      dn_work
);

    logic      valid_reg;
    logic      valid_next;
    bsm_work_t work_reg;
    bsm_work_t work_next;

    // Take a new request when empty or when the held one leaves
    assign up_ready = !valid_reg || dn_ready;

    always_comb
    begin
        bsm_work_t w;
        w = up_work;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            w = booth_step(w);
        end
        work_next  = (up_valid && up_ready) ? w : work_reg;
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !dn_ready |=> valid_reg && $stable(work_reg))
        else $error("stage dropped or changed a stalled request");

    a_fill_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready |=> valid_reg)
        else $error("stage lost an accepted request");

    a_steps_advance: assert property (@(posedge clk) disable iff (!rst_n)
        up_valid && up_ready && up_work.cnt < CNT_W'(WIDTH)
            |=> work_reg.cnt > $past(up_work.cnt))
        else $error("stage did not advance the Booth step count");

endmodule

`default_nettype wire

### design/booth_signed_multiplier_top.sv
`default_nettype none

// Channel    Role  Payload
// operands   sink  multiplicand[15:0] signed, multiplier[15:0] signed
// result     src   product[31:0] signed
//
// One operand pair enters per cycle unless the result side stalls; the
// product passes through NUM_STAGES stages of two Booth add-and-shift steps each.
// Reset clears every stage valid bit; the data registers are not reset.
// A stall on the result side reaches back through every full stage in the
// same cycle; bubbles in the pipe still take new requests while the output waits.

module booth_signed_multiplier_top
    import bsm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bsm_in_if.sink    operands,
    bsm_out_if.source result
);

    logic      stage_valid [NUM_STAGES+1];
    logic      stage_ready [NUM_STAGES+1];
    bsm_work_t stage_work  [NUM_STAGES+1];

    always_comb
    begin
        stage_work[0].a   = '0;
        stage_work[0].q   = ext_operand(operands.multiplier);
        stage_work[0].qm1 = 1'b0;
        stage_work[0].m   = ext_operand(operands.multiplicand);
        stage_work[0].cnt = '0;
    end

    assign stage_valid[0] = operands.valid;
    assign operands.ready = stage_ready[0];

    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        bsm_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[s]),
            .up_ready (stage_ready[s]),
            .up_work  (stage_work[s]),
            .dn_valid (stage_valid[s+1]),
            .dn_ready (stage_ready[s+1]),
            .dn_work  (stage_work[s+1])
        );
    end

    assign result.valid           = stage_valid[NUM_STAGES];
    assign stage_ready[NUM_STAGES] = result.ready;
    assign result.product         = fit_product(stage_work[NUM_STAGES]);

    a_all_steps_done: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> stage_work[NUM_STAGES].cnt == CNT_W'(WIDTH))
        else $error("product leaves before all Booth steps are done");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid[1] |-> operands.ready)
        else $error("input blocked while first stage is empty");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.product))
        else $error("stalled product dropped or changed");

endmodule

`default_nettype wire
